FILE: rtl/fbcr_pkg.sv
// Package for the framebuffer controller register front end.
// Holds the request and response beat types, block codes and register offsets.
// No dependencies.
`default_nettype none

package fbcr_pkg;

  // Register block selected by an access.
  typedef enum logic [1:0] {
    BLK_CTRL  = 2'd0,
    BLK_SW    = 2'd1,
    BLK_PAL   = 2'd2,
    BLK_NONE  = 2'd3
  } blk_e;

  // Access direction.
  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_e;

  // Byte offsets of the register (low) halves; the high half sits two bytes below.
  localparam logic [7:0] OFF_CSR     = 8'h02;
  localparam logic [7:0] OFF_LSR     = 8'h06;
  localparam logic [7:0] OFF_VBASE   = 8'h0A;
  localparam logic [7:0] OFF_ROWW    = 8'h0E;
  localparam logic [7:0] OFF_SWIC    = 8'h02;
  localparam logic [7:0] OFF_SWCLR   = 8'h06;
  localparam logic [7:0] OFF_SWSTAT  = 8'h0A;
  localparam logic [7:0] OFF_PADDR   = 8'h02;
  localparam logic [7:0] OFF_PDATA_H = 8'h04;
  localparam logic [7:0] OFF_PDATA   = 8'h06;
  localparam logic [7:0] OFF_PBCR    = 8'h0A;

  localparam logic [15:0] SENSE_MASK = 16'h0E00;
  localparam logic [15:0] VBL_BIT    = 16'h0004;

  // Pixel depth codes.
  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_8BPP  = 3'd3;
  localparam logic [2:0] DEPTH_XRGB  = 3'd4;

  // Palette gather phases.
  localparam logic [1:0] PH_RED   = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_BLUE  = 2'd2;

  // Reciprocal of 3 for a 16-bit dividend: q = (x * DIV3_MUL) >> DIV3_SHIFT.
  localparam logic [16:0] DIV3_MUL   = 17'h0AAAB;
  localparam int          DIV3_SHIFT = 17;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  block_sel;
    logic [7:0]  reg_offset;
    logic [15:0] write_data;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        palette_we;
    logic [7:0]  palette_index;
    logic [7:0]  palette_red;
    logic [7:0]  palette_green;
    logic [7:0]  palette_blue;
    logic        scanout_update;
    logic [31:0] scan_byte_offset;
    logic [19:0] scan_stride;
    logic [20:0] scan_width;
    logic [2:0]  depth_code;
    logic        irq_clear;
  } resp_t;

endpackage

`default_nettype wire

FILE: rtl/framebuffer_controller_registers.sv
// Register front end of the framebuffer controller: decode, register state and
// scanout descriptor build. Depends on fbcr_pkg.
//
// Usage:
//   Requests arrive on in_valid_i / in_data_i and are taken at each rising edge
//   where in_valid_i is high and in_stall_o is low. Every request produces one
//   response beat on out_valid_o / out_data_o, taken when out_stall_i is low.
//   A request is captured in an input register and is processed from there
//   into the response register once that register can advance. One request
//   per cycle is sustained while the receiver does not stall; the rate is set
//   by the single decode and update path between the two registers, which also
//   holds the two divide-by-3 reciprocal multipliers of the XRGB descriptor.
//   While the receiver stalls, the response register holds, and one more
//   request is still taken into the input register; after that in_stall_o
//   stays high until the response moves on.
//   The user writes the sense code through cfg_we_i / cfg_wdata_i only while
//   idle; the block does not enforce this. Reset clears the state registers,
//   the pixel depth becomes 1 bpp and both channels come up empty.
`default_nettype none

module framebuffer_controller_registers (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire fbcr_pkg::req_t in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output fbcr_pkg::resp_t   out_data_o,
  input  wire               cfg_we_i,
  input  wire  [2:0]        cfg_wdata_i
);

  // Handshake and pipeline registers.
  logic             in_valid_q;
  fbcr_pkg::req_t   in_q;
  logic             out_valid_q;
  fbcr_pkg::resp_t  out_q, out_d;
  logic             out_adv;
  logic             proc_en;

  // Architectural state.
  logic [2:0]  sense_q;
  logic [15:0] cs_q, cs_d;
  logic [15:0] ls_q, ls_d;
  logic [15:0] vb_q, vb_d;
  logic [15:0] rw_q, rw_d;
  logic [15:0] swc_q, swc_d;
  logic [15:0] sws_q, sws_d;
  logic [7:0]  ptr_q, ptr_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] pend0_q, pend0_d;
  logic [31:0] pend1_q, pend1_d;
  logic [15:0] hh_q, hh_d;
  logic [15:0] dc_q, dc_d;
  logic [2:0]  pd_q, pd_d;

  // Decode helpers.
  logic        is_wr;
  logic [15:0] wval;
  logic [31:0] full_long;
  logic [2:0]  new_depth;
  logic        build;

  // Descriptor datapath.
  logic [32:0] rw_prod, vb_prod;
  logic [14:0] rw_q3, vb_q3;
  logic [15:0] rw_rem16, vb_rem16;
  logic [4:0]  rw_frac;
  logic [7:0]  vb_frac;
  logic [19:0] stride;
  logic [20:0] width;
  logic [31:0] offset;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign proc_en    = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;

  assign is_wr     = (in_q.req_type == fbcr_pkg::REQ_WRITE);
  assign wval      = in_q.write_data;
  assign full_long = {hh_q, wval};

  always_comb begin
    if (wval[4:3] == 2'b11 && wval[1]) begin
      new_depth = fbcr_pkg::DEPTH_XRGB;
    end else begin
      new_depth = {1'b0, wval[4:3]};
    end
  end

  // Decode and state update for the request in the input register.
  always_comb begin
    cs_d    = cs_q;
    ls_d    = ls_q;
    vb_d    = vb_q;
    rw_d    = rw_q;
    swc_d   = swc_q;
    sws_d   = sws_q;
    ptr_d   = ptr_q;
    phase_d = phase_q;
    pend0_d = pend0_q;
    pend1_d = pend1_q;
    hh_d    = hh_q;
    dc_d    = dc_q;
    pd_d    = pd_q;
    build   = 1'b0;
    out_d   = '0;

    case (fbcr_pkg::blk_e'(in_q.block_sel))
      fbcr_pkg::BLK_CTRL: begin
        if (is_wr) begin
          case (in_q.reg_offset)
            fbcr_pkg::OFF_CSR: begin
              cs_d = (wval & ~fbcr_pkg::SENSE_MASK) | (cs_q & fbcr_pkg::SENSE_MASK);
              // Master reset keeps only the sense field and restarts the palette gather.
              if (wval[0]) begin
                cs_d    = cs_q & fbcr_pkg::SENSE_MASK;
                phase_d = fbcr_pkg::PH_RED;
              end
            end
            fbcr_pkg::OFF_LSR: ls_d = wval;
            fbcr_pkg::OFF_VBASE: begin
              vb_d  = wval;
              build = 1'b1;
            end
            fbcr_pkg::OFF_ROWW: begin
              rw_d  = wval;
              build = 1'b1;
            end
            default: ;
          endcase
        end else begin
          case (in_q.reg_offset)
            fbcr_pkg::OFF_CSR:
              out_d.read_data = (cs_q & fbcr_pkg::SENSE_MASK) | {4'b0, sense_q, 9'b0};
            fbcr_pkg::OFF_LSR:   out_d.read_data = ls_q;
            fbcr_pkg::OFF_VBASE: out_d.read_data = vb_q;
            fbcr_pkg::OFF_ROWW:  out_d.read_data = rw_q;
            default: ;
          endcase
        end
      end
      fbcr_pkg::BLK_SW: begin
        if (is_wr) begin
          case (in_q.reg_offset)
            fbcr_pkg::OFF_SWIC:   swc_d = wval;
            fbcr_pkg::OFF_SWCLR:  out_d.irq_clear = 1'b1;
            fbcr_pkg::OFF_SWSTAT: sws_d = wval;
            default: ;
          endcase
        end else begin
          case (in_q.reg_offset)
            fbcr_pkg::OFF_SWSTAT: begin
              // Each status read flips the blank bit so polling loops see it change.
              sws_d           = sws_q ^ fbcr_pkg::VBL_BIT;
              out_d.read_data = sws_d & fbcr_pkg::VBL_BIT;
            end
            fbcr_pkg::OFF_SWIC: out_d.read_data = swc_q;
            default: ;
          endcase
        end
      end
      fbcr_pkg::BLK_PAL: begin
        if (is_wr) begin
          case (in_q.reg_offset)
            fbcr_pkg::OFF_PDATA_H: hh_d = wval;
            fbcr_pkg::OFF_PADDR: begin
              ptr_d   = wval[7:0];
              phase_d = fbcr_pkg::PH_RED;
            end
            fbcr_pkg::OFF_PDATA: begin
              hh_d = '0;
              case (phase_q)
                fbcr_pkg::PH_RED: begin
                  pend0_d = full_long;
                  phase_d = fbcr_pkg::PH_GREEN;
                end
                fbcr_pkg::PH_GREEN: begin
                  pend1_d = full_long;
                  phase_d = fbcr_pkg::PH_BLUE;
                end
                default: begin
                  // Third long completes the entry. A long with all three colors
                  // packed in its low bytes, after two zero longs, is taken whole.
                  out_d.palette_we    = 1'b1;
                  out_d.palette_index = ptr_q;
                  if (pend0_q == '0 && pend1_q == '0 && full_long[31:8] != '0) begin
                    out_d.palette_red   = full_long[7:0];
                    out_d.palette_green = full_long[15:8];
                    out_d.palette_blue  = full_long[23:16];
                  end else begin
                    out_d.palette_red   = pend0_q[7:0];
                    out_d.palette_green = pend1_q[7:0];
                    out_d.palette_blue  = full_long[7:0];
                  end
                  ptr_d   = ptr_q + 8'd1;
                  phase_d = fbcr_pkg::PH_RED;
                end
              endcase
            end
            fbcr_pkg::OFF_PBCR: begin
              dc_d = wval;
              if (new_depth != pd_q) begin
                pd_d  = new_depth;
                build = 1'b1;
              end
            end
            default: ;
          endcase
        end else begin
          case (in_q.reg_offset)
            fbcr_pkg::OFF_PADDR: out_d.read_data = {8'b0, ptr_q};
            fbcr_pkg::OFF_PBCR:  out_d.read_data = dc_q;
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    out_d.depth_code = pd_d;
    if (build && rw_d != '0) begin
      out_d.scanout_update   = 1'b1;
      out_d.scan_byte_offset = offset;
      out_d.scan_stride      = stride;
      out_d.scan_width       = width;
    end
  end

  // Divide by 3 through a reciprocal multiply; the remainder then picks the
  // fractional part of x*32/3 or x*256/3.
  assign rw_prod  = 33'(rw_d) * 33'(fbcr_pkg::DIV3_MUL);
  assign vb_prod  = 33'(vb_d) * 33'(fbcr_pkg::DIV3_MUL);
  assign rw_q3    = rw_prod[fbcr_pkg::DIV3_SHIFT +: 15];
  assign vb_q3    = vb_prod[fbcr_pkg::DIV3_SHIFT +: 15];
  assign rw_rem16 = rw_d - ({1'b0, rw_q3} + {rw_q3, 1'b0});
  assign vb_rem16 = vb_d - ({1'b0, vb_q3} + {vb_q3, 1'b0});

  always_comb begin
    case (rw_rem16[1:0])
      2'd1:    rw_frac = 5'd10;
      2'd2:    rw_frac = 5'd21;
      default: rw_frac = 5'd0;
    endcase
    case (vb_rem16[1:0])
      2'd1:    vb_frac = 8'd85;
      2'd2:    vb_frac = 8'd170;
      default: vb_frac = 8'd0;
    endcase
  end

  always_comb begin
    if (pd_d == fbcr_pkg::DEPTH_XRGB) begin
      stride = {rw_q3, 5'b0} + 20'(rw_frac);
      width  = {3'b0, stride[19:2]};
      offset = {9'b0, vb_q3, 8'b0} + 32'(vb_frac);
    end else begin
      stride = {2'b0, rw_d, 2'b0};
      width  = {rw_d, 5'b0} >> pd_d[1:0];
      offset = {11'b0, vb_d, 5'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sense_q     <= '0;
      cs_q        <= '0;
      ls_q        <= '0;
      vb_q        <= '0;
      rw_q        <= '0;
      swc_q       <= '0;
      sws_q       <= '0;
      ptr_q       <= '0;
      phase_q     <= fbcr_pkg::PH_RED;
      pend0_q     <= '0;
      pend1_q     <= '0;
      hh_q        <= '0;
      dc_q        <= '0;
      pd_q        <= fbcr_pkg::DEPTH_1BPP;
    end else begin
      if (cfg_we_i) begin
        sense_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
      if (proc_en) begin
        cs_q    <= cs_d;
        ls_q    <= ls_d;
        vb_q    <= vb_d;
        rw_q    <= rw_d;
        swc_q   <= swc_d;
        sws_q   <= sws_d;
        ptr_q   <= ptr_d;
        phase_q <= phase_d;
        pend0_q <= pend0_d;
        pend1_q <= pend1_d;
        hh_q    <= hh_d;
        dc_q    <= dc_d;
        pd_q    <= pd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (proc_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("palette gather phase out of range");

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pd_q <= fbcr_pkg::DEPTH_XRGB)
    else $error("pixel depth out of range");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with no held request");

  a_pal_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.palette_we) |->
      (out_q.palette_red == '0 && out_q.palette_index == '0))
    else $error("palette fields set without a completed entry");

  a_entry_resets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_en && out_d.palette_we) |=> (phase_q == fbcr_pkg::PH_RED))
    else $error("palette phase not restarted after an entry");
`endif

endmodule

`default_nettype wire
